FILE: design/ntpc_pkg.sv
// ---------------------------------------------------------------------------
// ntpc_pkg
// Shared constants and types of the nearest-turn position command core.
// ---------------------------------------------------------------------------
package ntpc_pkg;

  // default length of one turn, hundredths of a degree
  localparam int TURN_UNITS_DEF = 36000;

  // field widths
  localparam int POS_W      = 32;
  localparam int MIN_TIME_W = 17;
  localparam int SPEED_W    = 24;
  localparam int TIME_W     = 17;

  // stream packing
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 56;
  localparam int TGT_LSB     = 0;
  localparam int MEAS_LSB    = 32;
  localparam int MINT_LSB    = 64;
  localparam int SPD_LSB     = 81;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_POSITION_MODE = 1'b0;
  localparam logic       MODE_RESET        = 1'b1;

  // timing
  localparam int MS_PER_SEC    = 1000;
  localparam int MS_SCALE_W    = 10;
  localparam int TIME_FLOOR_MS = 100;
  localparam int TIME_CEIL_MS  = 120000;

  // payload riding alongside the angle reduction
  typedef struct packed {
    logic signed [POS_W-1:0] current;
    logic [MIN_TIME_W-1:0]   min_time;
    logic [SPEED_W-1:0]      speed;
    logic                    acc;
  } front_t;

  // payload riding alongside the divider
  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [MIN_TIME_W-1:0]   min_time;
    logic                    spd_zero;
    logic                    acc;
  } back_t;

  // one result
  typedef struct packed {
    logic                    acc;
    logic signed [POS_W-1:0] pos;
    logic [TIME_W-1:0]       move_time;
  } res_t;

endpackage

FILE: design/ntpc_turn_reduce.sv
// ---------------------------------------------------------------------------
// ntpc_turn_reduce
// Four-stage floor modulo of a signed 32-bit angle by the turn length.
// ---------------------------------------------------------------------------
module ntpc_turn_reduce #(
  parameter int TURN_UNITS = ntpc_pkg::TURN_UNITS_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [31:0]             angle_i,
  output logic [$clog2(TURN_UNITS)-1:0]  turn_o
);

  localparam int RW = $clog2(TURN_UNITS);
  localparam int FL = $clog2(TURN_UNITS + 1) - 1;   // floor log2
  localparam int K  = 31 + FL;
  localparam int QB = 32 - FL;
  localparam logic [63:0] M64 = (64'd1 << K) / TURN_UNITS;
  localparam logic [63:0] C64 = (64'd1 << 31) % TURN_UNITS;
  localparam logic [31:0] RECIP  = M64[31:0];
  localparam logic [RW:0] TURN_V = (RW+1)'(TURN_UNITS);
  localparam logic [RW:0] OFFS_V = C64[RW:0];

  // offset binary: u = angle + 2^31, so angle mod T = (u mod T - 2^31 mod T) mod T
  logic [31:0]    u_nxt;
  logic [31:0]    u1_r, u2_r;
  logic [63:0]    prod_r;
  logic [QB-1:0]  q;
  logic [QB+RW:0] qt_full;
  logic [31:0]    qt_r;
  logic [31:0]    diff;
  logic [RW:0]    rem_nxt;
  logic [RW-1:0]  rem_r;
  logic [RW+1:0]  adj;
  logic [RW+1:0]  turn_nxt;
  logic [RW-1:0]  turn_r;

  assign u_nxt   = {~angle_i[31], angle_i[30:0]};
  assign q       = prod_r[K +: QB];
  assign qt_full = q * TURN_V;
  assign diff    = u2_r - qt_r;

  // quotient estimate is at most one low
  always_comb begin
    rem_nxt = diff[RW:0];
    if (rem_nxt >= TURN_V) begin
      rem_nxt = rem_nxt - TURN_V;
    end
  end

  always_comb begin
    adj      = {2'b00, rem_r} - {1'b0, OFFS_V};
    turn_nxt = adj;
    if (adj[RW+1]) begin
      turn_nxt = adj + {1'b0, TURN_V};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u_nxt;
      prod_r <= u_nxt * RECIP;
      u2_r   <= u1_r;
      qt_r   <= qt_full[31:0];
      rem_r  <= rem_nxt[RW-1:0];
      turn_r <= turn_nxt[RW-1:0];
    end
  end

  assign turn_o = turn_r;

endmodule

FILE: design/ntpc_div.sv
// ---------------------------------------------------------------------------
// ntpc_div
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module ntpc_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = ntpc_pkg::SPEED_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  // numerator shifts out at the top while quotient bits shift in below
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [NUM_W-1:0] nq_nxt[NUM_W];
  logic [DEN_W-1:0] rem_r  [NUM_W-1];
  logic [DEN_W-1:0] rem_nxt[NUM_W];
  logic [DEN_W-1:0] den_r  [NUM_W-1];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [NUM_W-1:0] nq_prev;
    logic [DEN_W-1:0] rem_prev;
    logic [DEN_W-1:0] den_prev;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    if (s == 0) begin : g_first
      assign nq_prev  = num_i;
      assign rem_prev = '0;
      assign den_prev = den_i;
    end else begin : g_next
      assign nq_prev  = nq_r[s-1];
      assign rem_prev = rem_r[s-1];
      assign den_prev = den_r[s-1];
    end

    always_comb begin
      rem_sh     = {rem_prev, nq_prev[NUM_W-1]};
      rem_sub    = rem_sh - {1'b0, den_prev};
      ge         = (rem_sh >= {1'b0, den_prev});
      rem_nxt[s] = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nq_nxt[s]  = {nq_prev[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[s] <= nq_nxt[s];
      end
    end

    if (s < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt[s];
          den_r[s] <= den_prev;
        end
      end
    end
  end

  assign quo_o = nq_r[NUM_W-1];

endmodule

FILE: design/nearest_turn_position_command_core.sv
// ---------------------------------------------------------------------------
// nearest_turn_position_command_core
// Shortest-way position command: wraps target and measured angle to one
// turn, takes the signed move, derives a clamped move time and the
// saturated absolute target; a command is refused unless the motor runs in position mode.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Contents
//  --------+-----------+--------------------+----------------------------------
//  in_     | slave     | tvalid/tready      | target, measured, min time, speed,
//          |           |                    | motor running (tuser)
//  out_    | master    | tvalid/tready      | command position, move time,
//          |           |                    | accepted (tuser)
//  cfg_    | APB slave | psel/penable/pready| position_mode at byte address 0
//
//  Throughput is one transaction per cycle while the skid register is empty.
//  Each transaction passes the turn reduction (reciprocal multiply,
//  back-multiply, correction, offset), the wrap and distance, the
//  bit-per-stage divider over NW = clog2(TURN_UNITS) + 10 bits, the time
//  clamps and the output register. The whole pipeline advances on one
//  enable; an output register plus a skid register (two entries)
//  decouples it from out_tready, and in_tready falls only while the skid
//  register is occupied.
//  Reset (rst_n, synchronous) clears valid bits and sets position_mode.
//  position_mode is sampled as a transaction enters.
// ---------------------------------------------------------------------------
module nearest_turn_position_command_core #(
  parameter int TURN_UNITS = ntpc_pkg::TURN_UNITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] target_angle, [63:32] measured_position, [80:64] minimum_time,
  // [104:81] move_speed, [111:105] zero
  input  logic [ntpc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] motor_running
  input  logic                              in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] command_position, [48:32] move_time, [55:49] zero
  output logic [ntpc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] accepted
  output logic                              out_tuser,
  // configuration
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ntpc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ntpc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ntpc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int RW  = $clog2(TURN_UNITS);
  localparam int NW  = RW + ntpc_pkg::MS_SCALE_W;
  localparam int NST = 6 + NW + 2;
  localparam logic signed [RW+1:0] TURN_S = (RW+2)'(TURN_UNITS);
  localparam logic signed [RW+1:0] HALF_S = (RW+2)'(TURN_UNITS / 2);
  localparam logic [NW-1:0] MS_V    = NW'(ntpc_pkg::MS_PER_SEC);
  localparam logic [NW-1:0] FLOOR_V = NW'(ntpc_pkg::TIME_FLOOR_MS);
  localparam logic [NW-1:0] CEIL_V  = NW'(ntpc_pkg::TIME_CEIL_MS);

  // ---------------- configuration ----------------
  logic mode_r;
  logic cfg_wr;
  logic cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == ntpc_pkg::REG_POSITION_MODE);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = cfg_hit ? {{(ntpc_pkg::CFG_DATA_W-1){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ntpc_pkg::MODE_RESET;
    end else if (cfg_wr && cfg_hit) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic [NST-1:0] vld_r;
  logic           skid_vld_r;
  logic           out_vld_r;

  // single enable: held only while the skid register is full
  assign en        = ~skid_vld_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // ---------------- stages 1-4: turn reduction ----------------
  logic signed [31:0] tgt_in;
  logic signed [31:0] meas_in;
  logic [RW-1:0]      turn_t;
  logic [RW-1:0]      turn_c;
  ntpc_pkg::front_t   front_nxt;
  ntpc_pkg::front_t   front_r[4];

  assign tgt_in  = in_tdata[ntpc_pkg::TGT_LSB  +: ntpc_pkg::POS_W];
  assign meas_in = in_tdata[ntpc_pkg::MEAS_LSB +: ntpc_pkg::POS_W];

  always_comb begin
    front_nxt.current  = meas_in;
    front_nxt.min_time = in_tdata[ntpc_pkg::MINT_LSB +: ntpc_pkg::MIN_TIME_W];
    front_nxt.speed    = in_tdata[ntpc_pkg::SPD_LSB +: ntpc_pkg::SPEED_W];
    front_nxt.acc      = in_tuser & mode_r;
  end

  ntpc_turn_reduce #(.TURN_UNITS(TURN_UNITS)) u_turn_tgt (
    .clk     (clk),
    .en      (en),
    .angle_i (tgt_in),
    .turn_o  (turn_t)
  );

  ntpc_turn_reduce #(.TURN_UNITS(TURN_UNITS)) u_turn_meas (
    .clk     (clk),
    .en      (en),
    .angle_i (meas_in),
    .turn_o  (turn_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      front_r[0] <= front_nxt;
      for (int i = 1; i < 4; i++) begin
        front_r[i] <= front_r[i-1];
      end
    end
  end

  // ---------------- stage 5: signed move, wrapped to half a turn ----------------
  logic signed [RW+1:0] d_raw;
  logic signed [RW+1:0] d_wrap;
  logic signed [RW:0]   delta_r;
  ntpc_pkg::front_t     s5_r;

  always_comb begin
    d_raw  = $signed({2'b00, turn_t}) - $signed({2'b00, turn_c});
    d_wrap = d_raw;
    if (d_raw > HALF_S) begin
      d_wrap = d_raw - TURN_S;
    end else if (d_raw < -HALF_S) begin
      d_wrap = d_raw + TURN_S;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      delta_r <= d_wrap[RW:0];
      s5_r    <= front_r[3];
    end
  end

  // ---------------- stage 6: distance scaling, target saturation ----------------
  logic [RW:0]                  d_abs;
  logic [NW-1:0]                num_nxt;
  logic signed [32:0]           psum;
  logic signed [31:0]           pos_sat;
  logic [NW-1:0]                num_r;
  logic [ntpc_pkg::SPEED_W-1:0] den_r;
  ntpc_pkg::back_t              b6_nxt;
  ntpc_pkg::back_t              b6_r;

  assign d_abs   = delta_r[RW] ? -delta_r : delta_r;
  assign num_nxt = NW'(d_abs[RW-1:0]) * MS_V;
  assign psum    = 33'(s5_r.current) + 33'(delta_r);

  always_comb begin
    pos_sat = psum[31:0];
    if (psum[32] != psum[31]) begin
      pos_sat = psum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    b6_nxt.pos      = pos_sat;
    b6_nxt.min_time = s5_r.min_time;
    b6_nxt.spd_zero = (s5_r.speed == '0);
    b6_nxt.acc      = s5_r.acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      den_r <= s5_r.speed;
      b6_r  <= b6_nxt;
    end
  end

  // ---------------- divider: NW stages ----------------
  logic [NW-1:0]   quo;
  ntpc_pkg::back_t back_r[NW];

  ntpc_div #(.NUM_W(NW), .DEN_W(ntpc_pkg::SPEED_W)) u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num_r),
    .den_i (den_r),
    .quo_o (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      back_r[0] <= b6_r;
      for (int i = 1; i < NW; i++) begin
        back_r[i] <= back_r[i-1];
      end
    end
  end

  // ---------------- stage T1: minimum time ----------------
  logic [NW-1:0]   min_ext;
  logic [NW-1:0]   t1_nxt;
  logic [NW-1:0]   t1_r;
  ntpc_pkg::back_t bk1_r;

  assign min_ext = NW'(back_r[NW-1].min_time);

  always_comb begin
    if (back_r[NW-1].spd_zero || (quo < min_ext)) begin
      t1_nxt = min_ext;
    end else begin
      t1_nxt = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r  <= t1_nxt;
      bk1_r <= back_r[NW-1];
    end
  end

  // ---------------- stage T2: time bounds, rejection ----------------
  logic [NW-1:0]   t2_clamp;
  ntpc_pkg::res_t  fin_nxt;
  ntpc_pkg::res_t  fin_r;

  always_comb begin
    t2_clamp = t1_r;
    if (t1_r < FLOOR_V) begin
      t2_clamp = FLOOR_V;
    end else if (t1_r > CEIL_V) begin
      t2_clamp = CEIL_V;
    end
    fin_nxt.acc       = bk1_r.acc;
    fin_nxt.pos       = bk1_r.acc ? bk1_r.pos : '0;
    fin_nxt.move_time = bk1_r.acc ? t2_clamp[ntpc_pkg::TIME_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  // ---------------- output register with skid ----------------
  logic           push;
  logic           pop;
  ntpc_pkg::res_t out_r;
  ntpc_pkg::res_t skid_r;

  assign push = en & vld_r[NST-1];
  assign pop  = out_vld_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_r <= fin_r;
      end else begin
        out_r <= fin_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.acc;
  assign out_tdata  = {{(ntpc_pkg::OUT_TDATA_W - ntpc_pkg::POS_W - ntpc_pkg::TIME_W){1'b0}},
                       out_r.move_time, out_r.pos};

endmodule

FILE: test/tb_nearest_turn_position_command_core.sv
// ---------------------------------------------------------------------------
// tb_nearest_turn_position_command_core
// Self-checking bench for the shortest-way position command core. A queue-fed
// stream driver and a stream monitor check every result against an in-bench
// predictor. Covers directed corner cases, mode changes over the APB port,
// random commands with bursty idling on both sides and a long output stall.
// ---------------------------------------------------------------------------
module tb_nearest_turn_position_command_core;
  import ntpc_pkg::*;

  localparam longint TURN      = TURN_UNITS_DEF;
  localparam longint HALF_TURN = TURN_UNITS_DEF / 2;
  localparam int     PIPE_LAT  = 35;    // core latency at 36000 units per turn
  localparam int     MSG_CAP   = 40;    // mismatch lines printed before going quiet
  localparam int     HOLD_LEN  = 300;   // long receiver stall, cycles

  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR  = CFG_ADDR_W'(4 * REG_POSITION_MODE);
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4 * (REG_POSITION_MODE + 1));

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // one command as it goes onto the input stream
  typedef struct packed {
    logic signed [POS_W-1:0] target;
    logic signed [POS_W-1:0] current;
    logic [MIN_TIME_W-1:0]   min_time;
    logic [SPEED_W-1:0]      speed;
    logic                    running;
  } move_cmd_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // bench-side copy of position_mode, reset value 1
  logic pos_mode = MODE_RESET;

  move_cmd_t cmd_backlog[$];       // commands waiting for the driver
  res_t      pending_results[$];   // predicted results, oldest first

  logic idle_on   = 1'b0;          // random idle bursts enabled on both sides
  logic in_taken  = 1'b0;          // input transaction completed at last rising edge
  int   send_gap  = 0;
  int   recv_gap  = 0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   hold_left   = 0;

  int mismatch_cnt = 0;
  int results_cnt  = 0;
  int issued_cnt   = 0;
  int rejected_cnt = 0;
  int half_cnt     = 0;
  int stall_cnt    = 0;

  nearest_turn_position_command_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed limit; a correct run finishes in well under a tenth of it
  initial begin
    #4_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------
  function automatic longint within_turn(longint a);
    longint r;
    r = a % TURN;
    return (r < 0) ? r + TURN : r;
  endfunction

  // shortest move, clamped time and saturated absolute target for one command
  function automatic res_t nearest_turn_result(move_cmd_t c, logic mode);
    res_t   r;
    longint cur, delta, span, spd, ms, pos, floor_ms;
    r = '0;
    if (!c.running || !mode)
      return r;
    cur   = longint'(c.current);
    delta = within_turn(longint'(c.target)) - within_turn(cur);
    // exactly half a turn stays as it is
    if (delta > HALF_TURN)
      delta -= TURN;
    else if (delta < -HALF_TURN)
      delta += TURN;
    floor_ms = longint'(c.min_time);
    ms       = floor_ms;
    spd      = longint'(c.speed);
    if (spd != 0) begin
      span = (delta < 0) ? -delta : delta;
      ms   = span * MS_PER_SEC / spd;
      if (ms < floor_ms)
        ms = floor_ms;
    end
    if (ms < TIME_FLOOR_MS)
      ms = TIME_FLOOR_MS;
    if (ms > TIME_CEIL_MS)
      ms = TIME_CEIL_MS;
    pos = cur + delta;
    if (pos > longint'($signed(S32_MAX)))
      pos = longint'($signed(S32_MAX));
    if (pos < longint'($signed(S32_MIN)))
      pos = longint'($signed(S32_MIN));
    r.acc       = 1'b1;
    r.pos       = pos[POS_W-1:0];
    r.move_time = ms[TIME_W-1:0];
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver: offers the next backlog entry once the current one is taken
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    move_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        in_tdata  <= {7'b0, c.speed, c.min_time, c.current, c.target};
        in_tuser  <= c.running;
        in_tvalid <= 1'b1;
        // idle burst after this transaction
        if (idle_on && $urandom_range(0, 5) == 0)
          send_gap <= $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold counted here
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_LEN - 1;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap   <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      recv_gap   <= $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: checks the output side first, then records what went in
  // -------------------------------------------------------------------------
  task automatic flag_mismatch(string what, longint want, longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= MSG_CAP)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    else if (mismatch_cnt == MSG_CAP + 1)
      $display("%0t: further mismatches not shown", $time);
  endtask

  always @(posedge clk) begin
    res_t                    want;
    move_cmd_t               seen;
    logic signed [POS_W-1:0] got_pos;
    logic [TIME_W-1:0]       got_time;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && !in_tready)
        stall_cnt++;

      if (out_tvalid && out_tready) begin
        got_pos  = out_tdata[POS_W-1:0];
        got_time = out_tdata[POS_W +: TIME_W];
        results_cnt++;
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: result with none expected, pos %0d time %0d accepted %0b",
                   $time, got_pos, got_time, out_tuser);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.acc)
            flag_mismatch("accepted", want.acc, out_tuser);
          if (got_pos !== want.pos)
            flag_mismatch("command_position", want.pos, got_pos);
          if (got_time !== want.move_time)
            flag_mismatch("move_time", want.move_time, got_time);
          if (want.acc)
            issued_cnt++;
          else
            rejected_cnt++;
        end
      end

      if (in_tvalid && in_tready) begin
        seen.target   = in_tdata[TGT_LSB +: POS_W];
        seen.current  = in_tdata[MEAS_LSB +: POS_W];
        seen.min_time = in_tdata[MINT_LSB +: MIN_TIME_W];
        seen.speed    = in_tdata[SPD_LSB +: SPEED_W];
        seen.running  = in_tuser;
        if (pos_mode && seen.running &&
            within_turn(longint'(seen.target)) - within_turn(longint'(seen.current))
            inside {HALF_TURN, -HALF_TURN})
          half_cnt++;
        pending_results.push_back(nearest_turn_result(seen, pos_mode));
      end
    end
  end

  // -------------------------------------------------------------------------
  // APB access, only while the core is idle
  // -------------------------------------------------------------------------
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    // writes outside the register list leave the mode alone
    if (addr == MODE_ADDR)
      pos_mode = data[0];
  endtask

  task automatic cfg_check_mode();
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = MODE_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (rd[0] !== pos_mode)
      flag_mismatch("position_mode readback", pos_mode, rd[0]);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic queue_cmd(input logic [31:0] tgt, input logic [31:0] cur,
                           input logic [16:0] mint, input logic [23:0] spd,
                           input logic run);
    move_cmd_t c;
    c.target   = tgt;
    c.current  = cur;
    c.min_time = mint;
    c.speed    = spd;
    c.running  = run;
    cmd_backlog.push_back(c);
  endtask

  function automatic move_cmd_t random_cmd();
    move_cmd_t c;
    int        off;
    c.target   = $urandom;
    c.current  = $urandom;
    c.min_time = MIN_TIME_W'($urandom_range(0, 3000));
    c.speed    = SPEED_W'($urandom_range(50, 200000));
    c.running  = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // raw fields over their full range
        c.min_time = MIN_TIME_W'($urandom_range(0, 131071));
        c.speed    = SPEED_W'($urandom);
      end
      3, 4, 5: begin
        // target within about a turn of the shaft
        off      = $urandom_range(0, 80000) - 40000;
        c.target = c.current + off;
      end
      6: begin
        // half a turn apart, either way, after some whole turns
        off      = ($urandom_range(0, 1) ? 18000 : -18000)
                   + 36000 * ($urandom_range(0, 20) - 10);
        c.target = c.current + off;
      end
      7: begin
        // shaft near either end of the 32-bit range
        off       = $urandom_range(0, 40000);
        c.current = $urandom_range(0, 1) ? S32_MAX - off : S32_MIN + off;
        c.target  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 35999);
      end
      8: begin
        c.speed    = '0;
        c.min_time = MIN_TIME_W'($urandom_range(0, 131071));
      end
      default: begin
        c.min_time = MIN_TIME_W'($urandom_range(100000, 131071));
        c.speed    = $urandom_range(0, 1) ? SPEED_W'($urandom)
                                          : SPEED_W'($urandom_range(1, 200));
      end
    endcase
    return c;
  endfunction

  task automatic queue_random(int n);
    repeat (n) cmd_backlog.push_back(random_cmd());
  endtask

  // returns once every command has gone in and every result has come out
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_tvalid || pending_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (PIPE_LAT + 6) @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // mode comes out of reset set
    cfg_check_mode();

    // directed corners with the reset mode
    queue_cmd(32'd0,       32'd0,       17'd0,      24'd0,        1'b1);
    queue_cmd(32'd18000,   32'd0,       17'd0,      24'd1000,     1'b1);  // +half turn
    queue_cmd(32'd0,       32'd18000,   17'd250,    24'd0,        1'b1);  // -half turn
    queue_cmd(32'd18001,   32'd0,       17'd0,      24'd36000,    1'b1);  // just past half
    queue_cmd(-32'sd1,     32'd1,       17'd0,      24'd2,        1'b1);  // across zero
    queue_cmd(S32_MIN,     S32_MAX,     17'd0,      24'hFF_FFFF,  1'b1);
    queue_cmd(S32_MAX,     S32_MIN,     17'h1_FFFF, 24'd0,        1'b1);  // big minimum
    queue_cmd(32'd11747,   S32_MAX,     17'd0,      24'd100,      1'b1);  // saturates high
    queue_cmd(32'd24252,   S32_MIN,     17'd0,      24'd100,      1'b1);  // saturates low
    queue_cmd(32'd9000,    32'd0,       17'd0,      24'd1,        1'b1);  // ceiling
    queue_cmd(32'd9000,    32'd0,       17'd200,    24'd90000,    1'b1);  // minimum wins
    queue_cmd(32'd9000,    32'd0,       17'd50,     24'd90000,    1'b1);
    queue_cmd(32'd9000,    32'd0,       17'd0,      24'd900000,   1'b1);  // floor
    queue_cmd(32'd180123,  -32'sd107877, 17'd7,     24'd0,        1'b1);  // whole turns only
    queue_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1_FFFF, 24'hFF_FFFF, 1'b1);
    queue_cmd(32'd123,     32'd456,     17'd777,    24'd888,      1'b0);  // motor stopped
    queue_cmd(S32_MIN,     S32_MIN,     17'h1_FFFF, 24'hFF_FFFF,  1'b0);
    queue_cmd(32'd18000,   32'd0,       17'd120001, 24'd5,        1'b1);
    queue_cmd(32'd100,     32'd0,       17'd119999, 24'd1000,     1'b1);
    wait_drained();

    // speed mode: every command refused, spare address ignored
    cfg_write(MODE_ADDR, 32'd0);
    cfg_check_mode();
    queue_cmd(32'd18000,   32'd0,       17'd0,      24'd1000,     1'b1);
    queue_cmd(S32_MAX,     S32_MIN,     17'h1_FFFF, 24'hFF_FFFF,  1'b1);
    wait_drained();
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    cfg_check_mode();
    queue_cmd(32'd5000,    32'd0,       17'd300,    24'd10,       1'b1);
    queue_cmd(32'd0,       32'd0,       17'd0,      24'd0,        1'b0);
    wait_drained();

    // random commands with idling on both sides
    cfg_write(MODE_ADDR, 32'hFFFF_FFFF);
    cfg_check_mode();
    idle_on = 1'b1;
    queue_random(300);
    wait_drained();

    // long receiver hold while the sender keeps offering: the core fills up
    idle_on = 1'b0;
    queue_random(150);
    @(posedge clk);
    hold_asked++;
    wait_drained();

    // random traffic in speed mode
    cfg_write(MODE_ADDR, 32'd0);
    idle_on = 1'b1;
    queue_random(60);
    wait_drained();

    cfg_write(MODE_ADDR, 32'd1);
    cfg_check_mode();
    queue_random(240);
    wait_drained();

    // closing stretch at full rate, no idling
    idle_on = 1'b0;
    queue_random(80);
    wait_drained();

    $display("Checked %0d results: %0d commands issued, %0d refused, %0d half-turn moves.",
             results_cnt, issued_cnt, rejected_cnt, half_cnt);
    $display("Input held off for %0d cycles; position mode toggled and read back.", stall_cnt);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
